[rtl/ust_pkg.sv]
// ust_pkg: shared types and constants for the unordered set table unit
// no dependencies; imported by ust_ram users and unordered_set_table_unit
`timescale 1ns / 1ps

package ust_pkg;

   // built table depth by default
   localparam int CAPACITY_DEF = 32;

   // fixed field widths of the channels
   localparam int VALUE_W    = 32;
   localparam int OP_W       = 2;
   localparam int POS_W      = 5;
   localparam int COUNT_W    = 6;
   localparam int CFG_W      = 6;

   // capacity limit register value after reset
   localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

   // request kinds
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_SWAP,
      ST_FINISH
   } state_type;

endpackage

[rtl/ust_ram.sv]
// ust_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no package dependency
`timescale 1ns / 1ps

module ust_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/unordered_set_table_unit.sv]
// unordered_set_table_unit: set of distinct 32-bit values in an unordered table
// depends on ust_pkg and ust_ram (entry store)
//
// Usage
//   req_ channel carries one item (operation, value): insert, remove or query.
//   rsp_ channel returns one item per request: success, full_reject, position
//   and member_count after the request.
//   csr_ channel writes the capacity limit (0 acts as 1, above CAPACITY acts as
//   CAPACITY); csr_ready is always high.
// Sequencing
//   one request at a time. A request passes through accept, a linear scan
//   reading one entry per cycle from the single ram read port, resolve, swap
//   for a remove and result load; a request that hits early or meets an empty
//   table finishes sooner, and operation code 3 goes from accept straight to
//   result load.
// Reset
//   synchronous, active high: count goes to zero and the limit to 32. The
//   entry ram is not cleared; only slots below count are ever read.
// Stall
//   the result sits in an output register; the next item is accepted while it
//   waits, and that item holds in its final step until the register is free.
`timescale 1ns / 1ps

module unordered_set_table_unit
   import ust_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [VALUE_W-1:0] req_value,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_success,
   output logic                      rsp_full_reject,
   output logic [POS_W-1:0]          rsp_position,
   output logic [COUNT_W-1:0]        rsp_member_count,
   // configuration channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CFG_W-1:0]          csr_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   state_type state_ff, state_in;

   logic [OP_W-1:0]    op_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_addr_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CFG_W-1:0]   limit_ff;
   logic               res_ok_ff;
   logic               res_full_ff;
   logic [IDX_W-1:0]   res_pos_ff;
   logic               rsp_valid_ff;
   logic               rsp_success_ff;
   logic               rsp_full_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   logic               req_take;
   logic               out_free;
   logic               issue;
   logic               hit;
   logic               last_cmp;
   logic [CNT_W-1:0]   count_m1;
   logic [LIM_W-1:0]   limit_ext;
   logic [LIM_W-1:0]   limit_eff;
   logic               table_full;
   logic               do_insert;
   logic               do_fetch_last;

   // entry store
   ust_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshake helpers
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // effective limit, saturated to 1..CAPACITY
   assign limit_ext = LIM_W'(limit_ff);
   always_comb begin
      limit_eff = limit_ext;
      if (limit_ext == '0) begin
         limit_eff = LIM_W'(1);
      end else if (limit_ext > LIM_W'(CAPACITY)) begin
         limit_eff = LIM_W'(CAPACITY);
      end
   end
   assign table_full = (LIM_W'(count_ff) >= limit_eff);

   // scan: one read issued per cycle, compared in the following cycle
   assign count_m1 = count_ff - CNT_W'(1);
   assign issue    = (state_ff == ST_SCAN) && (idx_ff < count_ff);
   assign hit      = pend_ff && (ram_rd_data == val_ff);
   assign last_cmp = pend_ff && (CNT_W'(pend_addr_ff) == count_m1);

   // resolve-step actions
   assign do_insert = (state_ff == ST_RESOLVE) && (op_ff == OP_INSERT)
                      && !found_ff && !table_full;
   assign do_fetch_last = (state_ff == ST_RESOLVE) && (op_ff == OP_REMOVE) && found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_operation) inside
                  OP_INSERT, OP_REMOVE, OP_QUERY: begin
                     state_in = (count_ff == '0) ? ST_RESOLVE : ST_SCAN;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit || last_cmp) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            state_in = do_fetch_last ? ST_SWAP : ST_FINISH;
         end
         ST_SWAP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ram controls
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[IDX_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = val_ff;
      unique case (state_ff)
         ST_SCAN: begin
            ram_rd_en = issue;
         end
         ST_RESOLVE: begin
            // append on insert, fetch last entry on a remove hit
            ram_wr_en   = do_insert;
            ram_rd_en   = do_fetch_last;
            ram_rd_addr = count_m1[IDX_W-1:0];
         end
         ST_SWAP: begin
            // last entry moves into the freed slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_ff;
            ram_wr_data = ram_rd_data;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         pend_ff <= issue;
         if (do_insert) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (state_ff == ST_SWAP) begin
            count_ff <= count_m1;
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and scan working registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= req_operation;
         val_ff      <= req_value;
         idx_ff      <= '0;
         found_ff    <= 1'b0;
         slot_ff     <= '0;
         res_ok_ff   <= 1'b0;
         res_full_ff <= 1'b0;
         res_pos_ff  <= '0;
      end
      if (issue) begin
         idx_ff       <= idx_ff + CNT_W'(1);
         pend_addr_ff <= idx_ff[IDX_W-1:0];
      end
      if (state_ff == ST_SCAN && hit) begin
         found_ff <= 1'b1;
         slot_ff  <= pend_addr_ff;
      end
      // outcome of the request
      if (state_ff == ST_RESOLVE) begin
         case (op_ff) inside
            OP_INSERT: begin
               if (found_ff) begin
                  res_pos_ff <= slot_ff;
               end else if (table_full) begin
                  res_full_ff <= 1'b1;
               end else begin
                  res_ok_ff  <= 1'b1;
                  res_pos_ff <= count_ff[IDX_W-1:0];
               end
            end
            OP_REMOVE, OP_QUERY: begin
               if (found_ff) begin
                  res_ok_ff  <= 1'b1;
                  res_pos_ff <= slot_ff;
               end
            end
            default: begin
               res_ok_ff <= 1'b0;
            end
         endcase
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && out_free) begin
         rsp_success_ff <= res_ok_ff;
         rsp_full_ff    <= res_full_ff;
         rsp_pos_ff     <= POS_W'(res_pos_ff);
         rsp_count_ff   <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_full_reject  = rsp_full_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_member_count = rsp_count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_wr_en)
      else $error("entry write during scan");

   a_swap_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWAP) |-> (count_ff != '0))
      else $error("swap with empty table");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && state_ff != ST_FINISH) |=> !rsp_valid_ff)
      else $error("result raised outside final step");

endmodule
